/* src/svptw_pkg.sv */
// Shared types and constants for the Sv48 page table walker.
// No dependencies; every other file in src imports this package.
package svptw_pkg;

	localparam int VA_W       = 64;
	localparam int ADDR_W     = 56;
	localparam int PPN_W      = 44;
	localparam int PPN_LSB    = 10;
	localparam int INDEX_BITS = 9;
	localparam int PAGE_SHIFT = 12;
	localparam int APB_DW     = 64;
	localparam int APB_AW     = 5;

	localparam logic MODE_REQ  = 1'b0;
	localparam logic MODE_RESP = 1'b1;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	localparam logic [1:0] REG_ROOT = 2'd0;
	localparam logic [1:0] REG_BASE = 2'd1;
	localparam logic [1:0] REG_SIZE = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] root_table_addr;
		logic [VA_W-1:0]   window_base;
		logic [VA_W-1:0]   window_size;
	} cfg_t;

	typedef struct packed {
		logic            mode;
		logic [VA_W-1:0] virt_addr;
		logic [VA_W-1:0] entry_data;
	} req_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] read_addr;
		logic [1:0]        status;
		logic [ADDR_W-1:0] phys_addr;
		logic [1:0]        leaf_level;
		logic              perm_read;
		logic              perm_write;
		logic              perm_exec;
		logic              perm_user;
	} rsp_t;

endpackage

/* src/svptw_req_if.sv */
// Input channel: translate requests and memory responses.
// Depends on svptw_pkg for field widths.
interface svptw_req_if;
	import svptw_pkg::*;

	logic            valid;
	logic            ready;
	logic            mode;
	logic [VA_W-1:0] virt_addr;
	logic [VA_W-1:0] entry_data;

	modport source (output valid, mode, virt_addr, entry_data, input ready);
	modport sink (input valid, mode, virt_addr, entry_data, output ready);
endinterface

/* src/svptw_rsp_if.sv */
// Output channel: memory read requests and final translation results.
// Depends on svptw_pkg for field widths.
interface svptw_rsp_if;
	import svptw_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [ADDR_W-1:0] read_addr;
	logic [1:0]        status;
	logic [ADDR_W-1:0] phys_addr;
	logic [1:0]        leaf_level;
	logic              perm_read;
	logic              perm_write;
	logic              perm_exec;
	logic              perm_user;

	modport source (output valid, kind, read_addr, status, phys_addr, leaf_level,
		perm_read, perm_write, perm_exec, perm_user, input ready);
	modport sink (input valid, kind, read_addr, status, phys_addr, leaf_level,
		perm_read, perm_write, perm_exec, perm_user, output ready);
endinterface

/* src/svptw_cfg.sv */
// APB register block: root table address, window base and window size.
// Depends on svptw_pkg.
module svptw_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [svptw_pkg::APB_AW-1:0]  paddr,
	input  logic [svptw_pkg::APB_DW-1:0]  pwdata,
	output logic [svptw_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	output svptw_pkg::cfg_t               cfg
);
	import svptw_pkg::*;

	logic [ADDR_W-1:0] root_q;
	logic [VA_W-1:0]   base_q;
	logic [VA_W-1:0]   size_q;
	logic [1:0]        reg_idx;
	logic              wr_en;

	assign reg_idx = paddr[4:3];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			base_q <= '0;
			size_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ROOT: root_q <= pwdata[ADDR_W-1:0];
				REG_BASE: base_q <= pwdata;
				REG_SIZE: size_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROOT: prdata = APB_DW'(root_q);
			REG_BASE: prdata = base_q;
			REG_SIZE: prdata = size_q;
			default:  prdata = '0;
		endcase
	end

	assign cfg.root_table_addr = root_q;
	assign cfg.window_base     = base_q;
	assign cfg.window_size     = size_q;
endmodule

/* src/svptw_walk.sv */
// Walk state and combinational step logic: window check, entry address,
// entry decode and result formation. Depends on svptw_pkg.
module svptw_walk #(
	parameter int LEVELS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  svptw_pkg::req_t item,
	input  svptw_pkg::cfg_t cfg,
	output logic            has_result,
	output svptw_pkg::rsp_t result,
	output logic            walk_busy
);
	import svptw_pkg::*;

	localparam int               LVL_W   = $clog2(LEVELS);
	localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LEVELS - 1);

	logic              busy_q, busy_d;
	logic [LVL_W-1:0]  level_q, level_d;
	logic [VA_W-1:0]   vaddr_q, vaddr_d;

	logic [VA_W-1:0]       last;
	logic                  in_window;
	logic [ADDR_W-1:0]     ppn_base;
	logic                  ent_v;
	logic                  is_ptr;
	logic [ADDR_W-1:0]     tbl;
	logic [VA_W-1:0]       idx_va;
	logic [LVL_W-1:0]      idx_lvl;
	logic [INDEX_BITS-1:0] idx;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ADDR_W-1:0]     pmask;

	assign last      = cfg.window_base + cfg.window_size - VA_W'(1);
	assign in_window = (item.virt_addr >= cfg.window_base) && (item.virt_addr <= last);
	assign ppn_base  = {item.entry_data[PPN_LSB +: PPN_W], {PAGE_SHIFT{1'b0}}};
	assign ent_v     = item.entry_data[0];
	assign is_ptr    = (item.entry_data[3:1] == 3'b000);

	always_comb begin
		if (item.mode == MODE_REQ) begin
			tbl     = cfg.root_table_addr;
			idx_va  = item.virt_addr;
			idx_lvl = TOP_LVL;
		end else begin
			tbl     = ppn_base;
			idx_va  = vaddr_q;
			idx_lvl = level_q - LVL_W'(1);
		end
	end

	always_comb begin
		idx   = '0;
		pmask = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (idx_lvl == LVL_W'(l))
				idx = idx_va[PAGE_SHIFT + INDEX_BITS*l +: INDEX_BITS];
			if (level_q == LVL_W'(l))
				pmask = ADDR_W'((64'd1 << (PAGE_SHIFT + INDEX_BITS*l)) - 64'd1);
		end
	end

	assign rd_addr = tbl + ADDR_W'({idx, 3'b000});

	always_comb begin
		busy_d     = busy_q;
		level_d    = level_q;
		vaddr_d    = vaddr_q;
		has_result = 1'b0;
		result     = '0;
		if (item.mode == MODE_REQ) begin
			has_result = 1'b1;
			level_d    = TOP_LVL;
			if (!in_window) begin
				busy_d        = 1'b0;
				result.kind   = KIND_FINAL;
				result.status = ST_RANGE;
			end else begin
				busy_d           = 1'b1;
				vaddr_d          = item.virt_addr;
				result.kind      = KIND_READ;
				result.read_addr = rd_addr;
			end
		end else if (busy_q) begin
			has_result = 1'b1;
			priority if (!ent_v || (is_ptr && level_q == '0)) begin
				busy_d        = 1'b0;
				level_d       = TOP_LVL;
				result.kind   = KIND_FINAL;
				result.status = ST_NOTFOUND;
			end else if (is_ptr) begin
				level_d          = idx_lvl;
				result.kind      = KIND_READ;
				result.read_addr = rd_addr;
			end else begin
				busy_d            = 1'b0;
				level_d           = TOP_LVL;
				result.kind       = KIND_FINAL;
				result.status     = ST_OK;
				result.phys_addr  = ppn_base | (vaddr_q[ADDR_W-1:0] & pmask);
				result.leaf_level = level_q[1:0];
				result.perm_read  = item.entry_data[1];
				result.perm_write = item.entry_data[2];
				result.perm_exec  = item.entry_data[3];
				result.perm_user  = item.entry_data[4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			level_q <= TOP_LVL;
			vaddr_q <= '0;
		end else if (advance) begin
			busy_q  <= busy_d;
			level_q <= level_d;
			vaddr_q <= vaddr_d;
		end
	end

	assign walk_busy = busy_q;
endmodule

/* src/sv48_page_table_walker_core.sv */
// Sv48 page table walker top level: input register, walk step, result register.
// Depends on svptw_pkg, svptw_req_if, svptw_rsp_if, svptw_cfg, svptw_walk.
//
// Usage:
//   req carries either a translate request (mode 0, virt_addr) or a memory
//   response (mode 1, entry_data) for the last read request issued.
//   rsp carries either a read request (kind 0, read_addr) for the memory
//   side, or a final result (kind 1, status, phys_addr, level, permissions).
//   A response that arrives with no walk in progress gives no item on rsp.
//   A new request while a walk is in progress drops that walk.
//   Config (root table, window base, window size) is written over APB at
//   byte addresses 0, 8, 16 while the walker is idle; pready is tied high.
// Timing:
//   An item on req passes through the input register and then the result
//   register before it reaches rsp. Throughput is one item per cycle while rsp
//   is not stalled; the step logic between the two registers is combinational.
// Reset and stalls:
//   arst_n clears the config, the walk state and both valid flags.
//   When rsp is stalled the result register holds; one more item waits in the
//   input register, after which req.ready drops until rsp drains.
module sv48_page_table_walker_core #(
	parameter int LEVELS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	svptw_req_if.sink                    req,
	svptw_rsp_if.source                  rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [svptw_pkg::APB_AW-1:0] paddr,
	input  logic [svptw_pkg::APB_DW-1:0] pwdata,
	output logic [svptw_pkg::APB_DW-1:0] prdata,
	output logic                         pready
);
	import svptw_pkg::*;

	cfg_t cfg;
	req_t item_s1;
	logic valid_s1;
	rsp_t rsp_s2;
	logic valid_s2;
	logic advance;
	logic has_result;
	rsp_t result;
	logic walk_busy;

	svptw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	svptw_walk #(.LEVELS(LEVELS)) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.cfg        (cfg),
		.has_result (has_result),
		.result     (result),
		.walk_busy  (walk_busy)
	);

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (advance)
				valid_s2 <= has_result;
			else if (rsp.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.mode       <= req.mode;
			item_s1.virt_addr  <= req.virt_addr;
			item_s1.entry_data <= req.entry_data;
		end
		if (advance && has_result)
			rsp_s2 <= result;
	end

	assign rsp.valid      = valid_s2;
	assign rsp.kind       = rsp_s2.kind;
	assign rsp.read_addr  = rsp_s2.read_addr;
	assign rsp.status     = rsp_s2.status;
	assign rsp.phys_addr  = rsp_s2.phys_addr;
	assign rsp.leaf_level = rsp_s2.leaf_level;
	assign rsp.perm_read  = rsp_s2.perm_read;
	assign rsp.perm_write = rsp_s2.perm_write;
	assign rsp.perm_exec  = rsp_s2.perm_exec;
	assign rsp.perm_user  = rsp_s2.perm_user;

	a_read_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.kind == KIND_READ |-> walk_busy)
		else $error("read request pending with no walk in progress");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.kind == KIND_FINAL |-> !walk_busy)
		else $error("final result pending while walk still busy");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && valid_s2 && !rsp.ready)
		else $error("input stalled without a full pipeline");
endmodule

/* test/sv48_page_table_walker_core_tb.sv */
// Self-checking testbench for sv48_page_table_walker_core: directed and random walks
// with random stalls on both channels, checked against an in-bench walk predictor.
// Depends on svptw_pkg, svptw_req_if, svptw_rsp_if and the walker RTL.
module sv48_page_table_walker_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import svptw_pkg::*;

	localparam int WALK_LEVELS  = 4;
	localparam int DRAIN_CYCLES = 6;
	localparam int ITEMS_PHASE  = 100;
	localparam int CYCLE_LIMIT  = 400000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	svptw_req_if req_bus();
	svptw_rsp_if rsp_bus();

	sv48_page_table_walker_core #(
		.LEVELS(WALK_LEVELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predictor copy of config and walk state
	logic [ADDR_W-1:0] root_pa;
	logic [VA_W-1:0]   win_base;
	logic [VA_W-1:0]   win_size;
	bit                walk_busy;
	int                walk_lvl;
	logic [VA_W-1:0]   walk_va;

	rsp_t pending_results[$];
	int   errors;
	int   items_sent;
	int   cycle_count;
	int   stall_left;
	bit   src_idle;
	bit   sink_idle;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sv48_page_table_walker_core_tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready)
				stall_left = sink_idle ? $urandom_range(0, 12) : 0;
			else if (stall_left > 0)
				stall_left--;
			rsp_bus.ready <= (stall_left == 0);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [ADDR_W-1:0] pte_addr(input logic [ADDR_W-1:0] tbl_pa,
		input logic [VA_W-1:0] va, input int lvl);
		logic [INDEX_BITS-1:0] idx;
		idx = INDEX_BITS'(va >> (PAGE_SHIFT + INDEX_BITS * lvl));
		return tbl_pa + ADDR_W'({idx, 3'b000});
	endfunction

	function automatic void end_walk(inout rsp_t res, input logic [1:0] st);
		res.kind = KIND_FINAL;
		res.status = st;
		walk_busy = 1'b0;
		walk_lvl = WALK_LEVELS - 1;
	endfunction

	// one accepted item -> zero or one expected result
	function automatic bit walk_step(input logic mode, input logic [VA_W-1:0] va,
		input logic [VA_W-1:0] pte, output rsp_t res);
		logic [VA_W-1:0]   last;
		logic [VA_W-1:0]   pmask;
		logic [ADDR_W-1:0] next_pa;
		res = '0;
		if (mode == MODE_REQ) begin
			last = win_base + win_size - 1;
			walk_busy = 1'b0;
			walk_lvl = WALK_LEVELS - 1;
			if (va < win_base || va > last) begin
				end_walk(res, ST_RANGE);
				return 1'b1;
			end
			walk_busy = 1'b1;
			walk_va = va;
			res.kind = KIND_READ;
			res.read_addr = pte_addr(root_pa, va, walk_lvl);
			return 1'b1;
		end
		if (!walk_busy)
			return 1'b0;
		next_pa = {pte[PPN_LSB +: PPN_W], {PAGE_SHIFT{1'b0}}};
		if (!pte[0]) begin
			end_walk(res, ST_NOTFOUND);
		end else if (pte[3:1] == 3'b000) begin
			if (walk_lvl == 0) begin
				end_walk(res, ST_NOTFOUND);
			end else begin
				walk_lvl--;
				res.kind = KIND_READ;
				res.read_addr = pte_addr(next_pa, walk_va, walk_lvl);
			end
		end else begin
			pmask = (64'd1 << (PAGE_SHIFT + INDEX_BITS * walk_lvl)) - 64'd1;
			res.phys_addr = next_pa | ADDR_W'(walk_va & pmask);
			res.leaf_level = 2'(walk_lvl);
			res.perm_read = pte[1];
			res.perm_write = pte[2];
			res.perm_exec = pte[3];
			res.perm_user = pte[4];
			end_walk(res, ST_OK);
		end
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %h, actual %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected item: kind %0d read_addr %h status %0d",
					rsp_bus.kind, rsp_bus.read_addr, rsp_bus.status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, rsp_bus.kind);
				check_field("read_addr", want.read_addr, rsp_bus.read_addr);
				check_field("status", want.status, rsp_bus.status);
				check_field("phys_addr", want.phys_addr, rsp_bus.phys_addr);
				check_field("leaf_level", want.leaf_level, rsp_bus.leaf_level);
				check_field("perm_read", want.perm_read, rsp_bus.perm_read);
				check_field("perm_write", want.perm_write, rsp_bus.perm_write);
				check_field("perm_exec", want.perm_exec, rsp_bus.perm_exec);
				check_field("perm_user", want.perm_user, rsp_bus.perm_user);
			end
		end
	end

	task automatic send_item(input logic mode, input logic [VA_W-1:0] va,
		input logic [VA_W-1:0] pte);
		int   gap;
		bit   has_res;
		rsp_t res;
		gap = src_idle ? $urandom_range(0, 12) : 0;
		repeat (gap) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.mode <= mode;
		req_bus.virt_addr <= va;
		req_bus.entry_data <= pte;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		has_res = walk_step(mode, va, pte, res);
		if (has_res)
			pending_results.push_back(res);
		items_sent++;
	endtask

	task automatic send_req(input logic [VA_W-1:0] va);
		send_item(MODE_REQ, va, rand64());
	endtask

	task automatic send_pte(input logic [VA_W-1:0] pte);
		send_item(MODE_RESP, rand64(), pte);
	endtask

	function automatic logic [63:0] pte_pointer();
		logic [63:0] r;
		r = rand64();
		r[3:1] = 3'b000;
		r[0] = 1'b1;
		return r;
	endfunction

	function automatic logic [63:0] pte_leaf();
		logic [63:0] r;
		r = rand64();
		r[0] = 1'b1;
		if (r[3:1] == 3'b000)
			r[$urandom_range(1, 3)] = 1'b1;
		return r;
	endfunction

	function automatic logic [63:0] pte_invalid();
		logic [63:0] r;
		r = rand64();
		r[0] = 1'b0;
		return r;
	endfunction

	function automatic logic [63:0] pick_va();
		logic [63:0] last;
		last = win_base + win_size - 1;
		case ($urandom_range(0, 19))
			0: begin
				return win_base;
			end
			1: begin
				return last;
			end
			2: begin
				return win_base - 1;
			end
			3: begin
				return last + 1;
			end
			4: begin
				return rand64();
			end
			default: begin
				return (win_size == 0) ? rand64() : win_base + rand64() % win_size;
			end
		endcase
	endfunction

	// config writes only with nothing in flight
	task automatic drain_results();
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ROOT: root_pa = value[ADDR_W-1:0];
			REG_BASE: win_base = value;
			REG_SIZE: win_size = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic cfg_all(input logic [63:0] root, input logic [63:0] base,
		input logic [63:0] size);
		cfg_write(REG_ROOT, root);
		cfg_write(REG_BASE, base);
		cfg_write(REG_SIZE, size);
	endtask

	// reset config: whole space in window, root at 0
	task automatic test_reset_config();
		send_pte(pte_leaf());
		send_req(64'h0);
		send_pte(64'hFFFF_FFFF_FFFF_FFF1);
		send_pte(pte_pointer());
		send_pte(pte_pointer());
		send_pte(pte_pointer());
		send_req('1);
		send_pte('1);
		send_req(rand64());
		send_pte(64'h0);
		drain_results();
	endtask

	task automatic test_leaf_levels();
		logic [63:0] root;
		root = rand64();
		root[11:0] = '0;
		cfg_all(root, 64'h1000, 64'h0000_1000_0000_0000);
		send_req(pick_va());
		send_pte(pte_pointer());
		send_pte(pte_leaf());
		send_req(win_base + rand64() % win_size);
		repeat (3) send_pte(pte_pointer());
		send_pte(pte_leaf());
		// new request drops the walk in progress
		send_req(win_base + rand64() % win_size);
		send_pte(pte_pointer());
		send_req(win_base + rand64() % win_size);
		send_pte(pte_leaf());
		drain_results();
	endtask

	task automatic test_window_edges();
		logic [63:0] last;
		cfg_write(REG_BASE, 64'h0000_7FFF_FFFF_F000);
		cfg_write(REG_SIZE, 64'h0000_0000_1000_0000);
		last = win_base + win_size - 1;
		send_req(win_base - 1);
		send_req(win_base);
		send_req(last);
		send_req(last + 1);
		drain_results();
		cfg_write(REG_SIZE, 64'h0);
		send_req(win_base);
		drain_results();
	endtask

	task automatic random_walk();
		int n;
		int pick;
		if ($urandom_range(0, 99) < 12) begin
			send_item(1'($urandom_range(0, 1)), rand64(), rand64());
		end else begin
			send_req(pick_va());
			n = $urandom_range(0, 4);
			repeat (n) send_pte(pte_pointer());
			if (n < 4) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					send_pte(pte_leaf());
				else if (pick < 8)
					send_pte(pte_invalid());
			end
		end
	endtask

	task automatic test_random_walks();
		logic [63:0] root;
		int stop_at;
		for (int p = 0; p < 6; p++) begin
			root = rand64();
			root[11:0] = '0;
			case (p)
				0: cfg_all(root, 64'h0, 64'h0);
				1: cfg_all('1, rand64(), 64'd1 << $urandom_range(20, 40));
				2: cfg_all(64'h0, 64'h0, '1);
				3: cfg_all(root, 64'hFFFF_FFFF_FFC0_0000, 64'h0000_0000_0040_0000);
				4: cfg_all(root, rand64(), 64'h1000);
				default: cfg_all(root, 64'h0, 64'h0);
			endcase
			src_idle = (p != 1) && (p != 3);
			sink_idle = (p != 1) && (p != 2);
			stop_at = items_sent + ITEMS_PHASE;
			while (items_sent < stop_at)
				random_walk();
			drain_results();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_bus.valid = 1'b0;
		req_bus.mode = MODE_REQ;
		req_bus.virt_addr = '0;
		req_bus.entry_data = '0;
		rsp_bus.ready = 1'b0;
		root_pa = '0;
		win_base = '0;
		win_size = '0;
		walk_busy = 1'b0;
		walk_lvl = WALK_LEVELS - 1;
		walk_va = '0;
		errors = 0;
		items_sent = 0;
		cycle_count = 0;
		stall_left = 0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_leaf_levels();
		test_window_edges();
		test_random_walks();

		if (errors == 0) begin
			$display("sv48_page_table_walker_core_tb: clean");
		end else begin
			$display("sv48_page_table_walker_core_tb: errors");
		end
		$finish;
	end

endmodule
